// File: rtl/mahd_pkg.sv
// Package for the MPEG audio header decoder: status codes, field layout,
// bitrate and sample-rate tables and the reciprocal table for the length divide.
// Used by mpeg_audio_header_decoder_core; depends on nothing.
package mahd_pkg;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FREE_FORMAT = 3'd1;
    localparam logic [2:0] ST_BAD_BITRATE = 3'd2;
    localparam logic [2:0] ST_RSVD_RATE   = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    // Raw version and layer codes
    localparam logic [1:0] VER_MPEG1 = 2'd3;
    localparam logic [1:0] VER_MPEG2 = 2'd2;
    localparam logic [1:0] LAY_I     = 2'd3;
    localparam logic [1:0] LAY_II    = 2'd2;
    localparam logic [1:0] LAY_RSVD  = 2'd0;

    localparam logic [3:0] BRI_FREE  = 4'h0;
    localparam logic [3:0] BRI_BAD   = 4'hF;
    localparam logic [1:0] SFI_RSVD  = 2'd3;

    // Widths of the length datapath
    localparam int NUM_W   = 26;   // bitrate * coefficient * 1000
    localparam int RECIP_W = 19;   // floor(2^32 / fs)
    localparam int RECIP_S = 32;   // reciprocal scale shift
    localparam int LEN_W   = 11;
    localparam int FS_W    = 16;
    localparam int BR_W    = 9;
    localparam int COEF_W  = 18;

    // Slot coefficients times 1000
    localparam logic [COEF_W-1:0] COEF_L1   = 18'd12000;
    localparam logic [COEF_W-1:0] COEF_144  = 18'd144000;
    localparam logic [COEF_W-1:0] COEF_72   = 18'd72000;

    typedef logic [BR_W-1:0] br_t;
    typedef br_t br_tab_t [16];

    localparam br_tab_t BR_V1_L1 = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192,
        9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam br_tab_t BR_V1_L2 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam br_tab_t BR_V1_L3 = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam br_tab_t BR_V2_L1 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam br_tab_t BR_V2_L23 = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48,
        9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    // Header fields that ride along the pipeline
    typedef struct packed {
        logic [2:0]      status;
        logic [1:0]      version_code;
        logic [1:0]      layer_code;
        logic [BR_W-1:0] bitrate_kbps;
        logic [FS_W-1:0] sample_rate_hz;
        logic            padding_bit;
        logic [1:0]      channel_mode;
        logic [1:0]      stereo_ext;
        logic [1:0]      emphasis;
        logic            protection_bit;
        logic [2:0]      flag_bits;
    } hdr_info_t;

    // Bitrate in kbps; zero for unsupported version or layer
    function automatic logic [BR_W-1:0] br_lookup(input logic [1:0] ver,
                                                 input logic [1:0] lay,
                                                 input logic [3:0] bri);
        logic [BR_W-1:0] br;
        br = '0;
        if (ver == VER_MPEG1) begin
            case (lay)
                LAY_I:    br = BR_V1_L1[bri];
                LAY_II:   br = BR_V1_L2[bri];
                LAY_RSVD: br = '0;
                default:  br = BR_V1_L3[bri];
            endcase
        end
        else if (ver == VER_MPEG2) begin
            case (lay)
                LAY_I:    br = BR_V2_L1[bri];
                LAY_RSVD: br = '0;
                default:  br = BR_V2_L23[bri];
            endcase
        end
        return br;
    endfunction

    // Sample rate in Hz; zero for reserved codes and other versions
    function automatic logic [FS_W-1:0] fs_lookup(input logic [1:0] ver,
                                                 input logic [1:0] sfi);
        logic [FS_W-1:0] fs;
        fs = '0;
        if (ver == VER_MPEG1) begin
            case (sfi)
                2'd0:    fs = 16'd44100;
                2'd1:    fs = 16'd48000;
                2'd2:    fs = 16'd32000;
                default: fs = '0;
            endcase
        end
        else if (ver == VER_MPEG2) begin
            case (sfi)
                2'd0:    fs = 16'd22050;
                2'd1:    fs = 16'd24000;
                2'd2:    fs = 16'd16000;
                default: fs = '0;
            endcase
        end
        return fs;
    endfunction

    // floor(2^32 / fs) for each supported rate; the estimate it gives is
    // at most one below the true quotient for any numerator below 2^26
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
                                                       input logic [1:0] sfi);
        logic [RECIP_W-1:0] r;
        r = '0;
        if (ver == VER_MPEG1) begin
            case (sfi)
                2'd0:    r = 19'd97391;
                2'd1:    r = 19'd89478;
                2'd2:    r = 19'd134217;
                default: r = '0;
            endcase
        end
        else begin
            case (sfi)
                2'd0:    r = 19'd194783;
                2'd1:    r = 19'd178956;
                2'd2:    r = 19'd268435;
                default: r = '0;
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/mpeg_audio_header_decoder_core.sv
// MPEG-1/MPEG-2 audio frame header decoder, five-stage pipeline.
// Depends on mahd_pkg for status codes, lookup tables and the header info struct.

// One header word enters per clock while in_stall is low; the sustained rate is one header
// per cycle with no bubbles while out_stall is low. The five register stages
// are: field decode and table lookup, bitrate times slot coefficient, multiply by
// the reciprocal of the sample rate, back-multiply of the quotient estimate, and a
// one-step correction with padding. Sync bits are not checked. A stall on the
// result side holds every stage that has no empty slot ahead of it, so requests
// are neither lost nor repeated; the input side sees stall only when the whole
// pipeline is full and the result is not taken.
module mpeg_audio_header_decoder_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                header_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [1:0]                 version_code,
    output logic [1:0]                 layer_code,
    output logic [mahd_pkg::BR_W-1:0]  bitrate_kbps,
    output logic [mahd_pkg::FS_W-1:0]  sample_rate_hz,
    output logic [mahd_pkg::LEN_W-1:0] frame_bytes,
    output logic                       padding_bit,
    output logic [1:0]                 channel_mode,
    output logic [1:0]                 stereo_ext,
    output logic [1:0]                 emphasis,
    output logic                       protection_bit,
    output logic [2:0]                 flag_bits
);
    import mahd_pkg::*;

    localparam int PROD_W = NUM_W + RECIP_W;
    localparam int QF_W   = LEN_W + FS_W;
    localparam int CMP_W  = QF_W + 1;

    // Stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage payload
    hdr_info_t          info1_reg, info2_reg, info3_reg, info4_reg, info5_reg;
    hdr_info_t          info1_next;
    logic [COEF_W-1:0]  coef1_reg, coef1_next;
    logic [RECIP_W-1:0] recip1_reg, recip1_next, recip2_reg;
    logic [NUM_W-1:0]   num2_reg, num2_next, num3_reg, num4_reg;
    logic [LEN_W-1:0]   qest3_reg, qest3_next, qest4_reg;
    logic [QF_W-1:0]    qf4_reg, qf4_next;
    logic [LEN_W-1:0]   len5_reg, len5_next;

    logic [PROD_W-1:0]  prod3;
    logic [CMP_W-1:0]   bound4;
    logic [LEN_W-1:0]   q4;

    // Advance a stage when it is empty or the one after it advances
    assign adv5     = !v5_reg || !out_stall;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: split fields, look up rates, pick status and coefficient
    always_comb
    begin
        logic [1:0] ver;
        logic [1:0] lay;
        logic [3:0] bri;
        logic [1:0] sfi;
        logic       supported;
        ver = header_word[20:19];
        lay = header_word[18:17];
        bri = header_word[15:12];
        sfi = header_word[11:10];
        supported = (ver == VER_MPEG1 || ver == VER_MPEG2) && (lay != LAY_RSVD);

        info1_next.version_code   = ver;
        info1_next.layer_code     = lay;
        info1_next.protection_bit = header_word[16];
        info1_next.padding_bit    = header_word[9];
        info1_next.channel_mode   = header_word[7:6];
        info1_next.stereo_ext     = header_word[5:4];
        info1_next.emphasis       = header_word[1:0];
        info1_next.flag_bits      = {header_word[8], header_word[3], header_word[2]};
        info1_next.sample_rate_hz = fs_lookup(ver, sfi);
        info1_next.bitrate_kbps   = br_lookup(ver, lay, bri);

        // Report the highest fault code that holds
        if (!supported)
            info1_next.status = ST_UNSUPPORTED;
        else if (sfi == SFI_RSVD)
            info1_next.status = ST_RSVD_RATE;
        else if (bri == BRI_BAD)
            info1_next.status = ST_BAD_BITRATE;
        else if (bri == BRI_FREE)
            info1_next.status = ST_FREE_FORMAT;
        else
            info1_next.status = ST_OK;

        if (lay == LAY_I)
            coef1_next = COEF_L1;
        else if (lay == LAY_II || ver == VER_MPEG1)
            coef1_next = COEF_144;
        else
            coef1_next = COEF_72;

        recip1_next = recip_lookup(ver, sfi);
    end

    // Stage 2: numerator = bitrate * coefficient * 1000
    always_comb
    begin
        logic [BR_W+COEF_W-1:0] p;
        p         = info1_reg.bitrate_kbps * coef1_reg;
        num2_next = p[NUM_W-1:0];
    end

    // Stage 3: quotient estimate from the reciprocal
    always_comb
    begin
        prod3      = num2_reg * recip2_reg;
        qest3_next = prod3[RECIP_S +: LEN_W];
    end

    // Stage 4: back-multiply the estimate
    assign qf4_next = qest3_reg * info3_reg.sample_rate_hz;

    // Stage 5: correct the estimate by one, add padding, scale Layer I slots to bytes, drop length on faults
    always_comb
    begin
        bound4 = {1'b0, qf4_reg} + {{(CMP_W-FS_W){1'b0}}, info4_reg.sample_rate_hz};
        if ({{(CMP_W-NUM_W){1'b0}}, num4_reg} >= bound4)
            q4 = qest4_reg + LEN_W'(1);
        else
            q4 = qest4_reg;

        if (info4_reg.status != ST_OK)
            len5_next = '0;
        else if (info4_reg.layer_code == LAY_I)
            len5_next = LEN_W'({q4 + LEN_W'(info4_reg.padding_bit), 2'b00});
        else
            len5_next = q4 + LEN_W'(info4_reg.padding_bit);
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            info1_reg  <= info1_next;
            coef1_reg  <= coef1_next;
            recip1_reg <= recip1_next;
        end
        if (adv2)
        begin
            info2_reg  <= info1_reg;
            num2_reg   <= num2_next;
            recip2_reg <= recip1_reg;
        end
        if (adv3)
        begin
            info3_reg  <= info2_reg;
            num3_reg   <= num2_reg;
            qest3_reg  <= qest3_next;
        end
        if (adv4)
        begin
            info4_reg  <= info3_reg;
            num4_reg   <= num3_reg;
            qest4_reg  <= qest3_reg;
            qf4_reg    <= qf4_next;
        end
        if (adv5)
        begin
            info5_reg  <= info4_reg;
            len5_reg   <= len5_next;
        end
    end

    // Drive the result ports from the last stage
    assign out_valid      = v5_reg;
    assign status         = info5_reg.status;
    assign version_code   = info5_reg.version_code;
    assign layer_code     = info5_reg.layer_code;
    assign bitrate_kbps   = info5_reg.bitrate_kbps;
    assign sample_rate_hz = info5_reg.sample_rate_hz;
    assign frame_bytes    = len5_reg;
    assign padding_bit    = info5_reg.padding_bit;
    assign channel_mode   = info5_reg.channel_mode;
    assign stereo_ext     = info5_reg.stereo_ext;
    assign emphasis       = info5_reg.emphasis;
    assign protection_bit = info5_reg.protection_bit;
    assign flag_bits      = info5_reg.flag_bits;

endmodule

// File: bench/mpeg_audio_header_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for mpeg_audio_header_decoder_core: directed header table, then random
// headers under random gaps and stalls; results match known rows or an in-bench decoder.
// Depends on mahd_pkg and the core RTL.
module mpeg_audio_header_decoder_core_tb;
    import mahd_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAY_III      = 2'd1;

    localparam int RANDOM_HEADERS = 1300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 80;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [10:0] frame_bytes;
        logic        padding_bit;
        logic [1:0]  channel_mode;
        logic [1:0]  stereo_ext;
        logic [1:0]  emphasis;
        logic        protection_bit;
        logic [2:0]  flag_bits;
    } hdr_result_t;

    typedef struct {
        logic [31:0] word;
        bit          has_known;
        hdr_result_t known;
    } header_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [31:0] header_word = 32'd0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] frame_bytes;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  stereo_ext;
    logic [1:0]  emphasis;
    logic        protection_bit;
    logic [2:0]  flag_bits;

    hdr_result_t pending_results [$];
    header_row_t directed_rows [$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          cycle_count = 0;
    logic        no_idle   = 1'b0;
    logic        long_hold = 1'b0;

    // Bitrate tables in kbps, indexed by bitrate index
    int unsigned kbps_v1_l1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352,
                                     384, 416, 448, 0};
    int unsigned kbps_v1_l2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                     256, 320, 384, 0};
    int unsigned kbps_v1_l3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                     224, 256, 320, 0};
    int unsigned kbps_v2_l1 [16] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176,
                                     192, 224, 256, 0};
    int unsigned kbps_v2_l23 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                      128, 144, 160, 0};

    mpeg_audio_header_decoder_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .header_word    (header_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .version_code   (version_code),
        .layer_code     (layer_code),
        .bitrate_kbps   (bitrate_kbps),
        .sample_rate_hz (sample_rate_hz),
        .frame_bytes    (frame_bytes),
        .padding_bit    (padding_bit),
        .channel_mode   (channel_mode),
        .stereo_ext     (stereo_ext),
        .emphasis       (emphasis),
        .protection_bit (protection_bit),
        .flag_bits      (flag_bits)
    );

    always #5 clk = ~clk;

    // Decode one header word into the result the core should produce
    function automatic hdr_result_t decode_header(input logic [31:0] word);
        hdr_result_t r;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  bri;
        logic [1:0]  sfi;
        int unsigned kbps;
        int unsigned hz;
        int unsigned bps;
        int unsigned len;
        ver  = word[20:19];
        lay  = word[18:17];
        bri  = word[15:12];
        sfi  = word[11:10];
        kbps = 0;
        hz   = 0;
        len  = 0;
        r    = '0;

        // Sample rate follows version alone
        if (ver == VER_MPEG1)
            hz = (sfi == 2'd0) ? 44100 : (sfi == 2'd1) ? 48000 : (sfi == 2'd2) ? 32000 : 0;
        else if (ver == VER_MPEG2)
            hz = (sfi == 2'd0) ? 22050 : (sfi == 2'd1) ? 24000 : (sfi == 2'd2) ? 16000 : 0;

        // Bitrate and status, highest fault wins
        if ((ver == VER_MPEG1 || ver == VER_MPEG2) && lay != LAY_RSVD)
        begin
            if (ver == VER_MPEG1)
                kbps = (lay == LAY_I) ? kbps_v1_l1[bri] :
                       (lay == LAY_II) ? kbps_v1_l2[bri] : kbps_v1_l3[bri];
            else
                kbps = (lay == LAY_I) ? kbps_v2_l1[bri] : kbps_v2_l23[bri];
            if (sfi == SFI_RSVD)
                r.status = ST_RSVD_RATE;
            else if (bri == BRI_BAD)
                r.status = ST_BAD_BITRATE;
            else if (bri == BRI_FREE)
                r.status = ST_FREE_FORMAT;
            else
                r.status = ST_OK;
        end
        else
        begin
            r.status = ST_UNSUPPORTED;
            kbps     = 0;
        end

        // Frame length; Layer I counts four-byte slots
        if (r.status == ST_OK && hz != 0)
        begin
            bps = kbps * 1000;
            if (lay == LAY_I)
                len = ((12 * bps) / hz + word[9]) * 4;
            else if (lay == LAY_II || ver == VER_MPEG1)
                len = (144 * bps) / hz + word[9];
            else
                len = (72 * bps) / hz + word[9];
        end

        r.version_code   = ver;
        r.layer_code     = lay;
        r.bitrate_kbps   = kbps[8:0];
        r.sample_rate_hz = hz[15:0];
        r.frame_bytes    = len[10:0];
        r.padding_bit    = word[9];
        r.channel_mode   = word[7:6];
        r.stereo_ext     = word[5:4];
        r.emphasis       = word[1:0];
        r.protection_bit = word[16];
        r.flag_bits      = {word[8], word[3], word[2]};
        return r;
    endfunction

    // Mostly well-formed headers with random content, the rest raw noise
    function automatic logic [31:0] random_header();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 3) != 0)
        begin
            w[20:19] = $urandom_range(0, 1) ? VER_MPEG1 : VER_MPEG2;
            w[18:17] = 2'($urandom_range(1, 3));
            w[15:12] = 4'($urandom_range(1, 14));
            w[11:10] = 2'($urandom_range(0, 2));
        end
        return w;
    endfunction

    task automatic add_row(input logic [31:0] word, input bit has_known, input hdr_result_t known);
        header_row_t row;
        row.word      = word;
        row.has_known = has_known;
        row.known     = known;
        directed_rows.push_back(row);
    endtask

    // Offer one request after a random gap and record its expected result on acceptance
    task automatic send_header(input logic [31:0] word, input bit has_known,
                               input hdr_result_t known);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        header_word <= word;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(has_known ? known : decode_header(word));
        sent_count++;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Stimulus: directed table, then random requests, then drain
    initial
    begin
        int i;
        add_row(32'h0000_0000, 1'b1, hdr_result_t'{ST_UNSUPPORTED, VER_MPEG25, LAY_RSVD,
                9'd0, 16'd0, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b0, 3'd0});
        add_row(32'hFFFF_FFFF, 1'b1, hdr_result_t'{ST_RSVD_RATE, VER_MPEG1, LAY_I,
                9'd0, 16'd0, 11'd0, 1'b1, 2'd3, 2'd3, 2'd3, 1'b1, 3'd7});
        add_row(32'hFFFB_0000, 1'b1, hdr_result_t'{ST_FREE_FORMAT, VER_MPEG1, LAY_III,
                9'd0, 16'd44100, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFFB_F000, 1'b1, hdr_result_t'{ST_BAD_BITRATE, VER_MPEG1, LAY_III,
                9'd0, 16'd44100, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFFB_9C00, 1'b1, hdr_result_t'{ST_RSVD_RATE, VER_MPEG1, LAY_III,
                9'd128, 16'd0, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFF9_0400, 1'b1, hdr_result_t'{ST_UNSUPPORTED, VER_MPEG1, LAY_RSVD,
                9'd0, 16'd48000, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFF1_0000, 1'b1, hdr_result_t'{ST_UNSUPPORTED, VER_MPEG2, LAY_RSVD,
                9'd0, 16'd22050, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFEB_9000, 1'b1, hdr_result_t'{ST_UNSUPPORTED, VER_RESERVED, LAY_III,
                9'd0, 16'd0, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFE3_9000, 1'b1, hdr_result_t'{ST_UNSUPPORTED, VER_MPEG25, LAY_III,
                9'd0, 16'd0, 11'd0, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFFB_9000, 1'b1, hdr_result_t'{ST_OK, VER_MPEG1, LAY_III,
                9'd128, 16'd44100, 11'd417, 1'b0, 2'd0, 2'd0, 2'd0, 1'b1, 3'd0});
        add_row(32'hFFFF_E800, 1'b0, '0);
        add_row(32'hFFFF_1200, 1'b0, '0);
        add_row(32'hFFFD_EA00, 1'b0, '0);
        add_row(32'hFFFD_1000, 1'b0, '0);
        add_row(32'hFFFB_E400, 1'b0, '0);
        add_row(32'hFFF7_E000, 1'b0, '0);
        add_row(32'hFFF5_E800, 1'b0, '0);
        add_row(32'hFFF3_1200, 1'b0, '0);
        add_row(32'hFFF2_E5FF, 1'b0, '0);
        add_row(32'h001B_9000, 1'b0, '0);
        add_row(32'hFFFA_9155, 1'b0, '0);
        add_row(32'hFFFA_90AA, 1'b0, '0);

        // Hold reset, then release on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_header(directed_rows[k].word, directed_rows[k].has_known,
                        directed_rows[k].known);

        for (i = 0; i < RANDOM_HEADERS; i++)
        begin
            // Every fourth block of 100 runs back to back on both sides
            no_idle <= ((i / 100) % 4 == 3);
            // Pause once until the pipeline is empty
            if (i == RANDOM_HEADERS / 2)
            begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            send_header(random_header(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** mpeg_audio_header_decoder_core: PASSED **");
        else
            $display("** mpeg_audio_header_decoder_core: FAILED **");
        $finish;
    end

    // Receiver: check each taken result, then stall a random number of cycles
    initial
    begin
        int          rx_wait;
        hdr_result_t exp_r;
        rx_wait = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no request pending, expected none actual %0d",
                             $time, frame_bytes);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("status", exp_r.status, status);
                    check_field("version_code", exp_r.version_code, version_code);
                    check_field("layer_code", exp_r.layer_code, layer_code);
                    check_field("bitrate_kbps", exp_r.bitrate_kbps, bitrate_kbps);
                    check_field("sample_rate_hz", exp_r.sample_rate_hz, sample_rate_hz);
                    check_field("frame_bytes", exp_r.frame_bytes, frame_bytes);
                    check_field("padding_bit", exp_r.padding_bit, padding_bit);
                    check_field("channel_mode", exp_r.channel_mode, channel_mode);
                    check_field("stereo_ext", exp_r.stereo_ext, stereo_ext);
                    check_field("emphasis", exp_r.emphasis, emphasis);
                    check_field("protection_bit", exp_r.protection_bit, protection_bit);
                    check_field("flag_bits", exp_r.flag_bits, flag_bits);
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 4);
            end
            out_stall <= long_hold || (rx_wait != 0);
            if (rx_wait != 0)
                rx_wait--;
        end
    end

    // Hold off the result side once for a long stretch so the input backs up
    initial
    begin
        while (sent_count < 300) @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("** mpeg_audio_header_decoder_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/mahd_pkg.sv
rtl/mpeg_audio_header_decoder_core.sv
bench/mpeg_audio_header_decoder_core_tb.sv
